FILE: rtl/text_console_tile_writer_assert.svh
// Assertion macros for the text console tile writer.
`ifndef TEXT_CONSOLE_TILE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_TILE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("text console tile writer check failed");
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("text console tile writer check failed");
`else
`define TCW_ASSERT_SAME(label, clk, rst, ante, cons)
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/tcw_pkg.sv
// Types and constants shared by the text console tile writer modules.
package tcw_pkg;

   localparam int FUNC_W      = 2;
   localparam int CHAR_W      = 8;
   localparam int READ_ROW_W  = 5;
   localparam int READ_COL_W  = 5;
   localparam int CELL_W      = 16;
   localparam int CUR_COL_W   = 6;
   localparam int CUR_ROW_W   = 5;
   localparam int PAL_W       = 4;
   localparam int TILE_CODE_W = CELL_W - PAL_W;

   localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'd32;
   localparam logic [CHAR_W-1:0] LAST_PRINTABLE  = 8'd127;
   localparam logic [PAL_W-1:0]  PALETTE_RESET   = 4'hF;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PRINT   = 2'd0,
      FUNC_NEWLINE = 2'd1,
      FUNC_CLEAR   = 2'd2,
      FUNC_READ    = 2'd3
   } tcw_func_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_PRINT,
      ST_COPY,
      ST_FILL,
      ST_CLEAR,
      ST_RESPOND
   } tcw_state_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_HOME,
      CUR_NEWLINE,
      CUR_ADVANCE
   } tcw_cur_op_type;

   typedef struct packed {
      logic           req_load;
      tcw_cur_op_type cur_op;
      logic           sweep_clr;
      logic           sweep_inc;
      logic           write_zero;
      logic           write_char;
      logic           read_req;
      logic           copy;
      logic           respond;
   } tcw_cmd_type;

   typedef struct packed {
      logic printable;
      logic wrap;
      logic at_bottom;
      logic copy_last;
      logic sweep_last;
      logic copy_pend;
   } tcw_status_type;

endpackage

FILE: rtl/tcw_ctrl.sv
// Sequencer for the text console tile writer: decodes requests and walks scroll and clear.
module tcw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [1:0]               req_func,
   input  tcw_pkg::tcw_status_type  status,
   output logic                     busy,
   output tcw_pkg::tcw_cmd_type     cmd
);
   import tcw_pkg::*;

   tcw_state_type state_ff, state_in;
   logic          pend_print_ff, pend_print_in;
   tcw_func_type  func;

   assign func = tcw_func_type'(req_func);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         pend_print_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_print_ff <= pend_print_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      pend_print_in = pend_print_ff;
      cmd           = '0;
      cmd.cur_op    = CUR_HOLD;
      busy          = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_INIT: begin
            cmd.write_zero = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.sweep_inc = 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.req_load = 1'b1;
               unique case (func)
                  FUNC_PRINT: begin
                     if (!status.printable) begin
                        state_in = ST_RESPOND;
                     end else if (status.wrap) begin
                        cmd.cur_op = CUR_NEWLINE;
                        if (status.at_bottom) begin
                           cmd.sweep_clr = 1'b1;
                           pend_print_in = 1'b1;
                           state_in      = ST_COPY;
                        end else begin
                           state_in = ST_PRINT;
                        end
                     end else begin
                        state_in = ST_PRINT;
                     end
                  end
                  FUNC_NEWLINE: begin
                     cmd.cur_op = CUR_NEWLINE;
                     if (status.at_bottom) begin
                        cmd.sweep_clr = 1'b1;
                        pend_print_in = 1'b0;
                        state_in      = ST_COPY;
                     end else begin
                        state_in = ST_RESPOND;
                     end
                  end
                  FUNC_CLEAR: begin
                     cmd.cur_op    = CUR_HOME;
                     cmd.sweep_clr = 1'b1;
                     state_in      = ST_CLEAR;
                  end
                  FUNC_READ: begin
                     cmd.read_req = 1'b1;
                     state_in     = ST_RESPOND;
                  end
               endcase
            end
         end
         ST_PRINT: begin
            cmd.write_char = 1'b1;
            cmd.cur_op     = CUR_ADVANCE;
            state_in       = ST_RESPOND;
         end
         ST_COPY: begin
            cmd.copy      = 1'b1;
            cmd.sweep_inc = 1'b1;
            if (status.copy_last) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (!status.copy_pend) begin
               cmd.write_zero = 1'b1;
               if (status.sweep_last) begin
                  state_in      = pend_print_ff ? ST_PRINT : ST_RESPOND;
                  pend_print_in = 1'b0;
               end else begin
                  cmd.sweep_inc = 1'b1;
               end
            end
         end
         ST_CLEAR: begin
            cmd.write_zero = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_RESPOND;
            end else begin
               cmd.sweep_inc = 1'b1;
            end
         end
         ST_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

FILE: rtl/tcw_datapath.sv
// Tile map memory, cursor, palette register and result registers of the text console.
module tcw_datapath #(
   parameter int COLUMNS = 32,
   parameter int ROWS    = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tcw_pkg::tcw_cmd_type              cmd,
   output tcw_pkg::tcw_status_type           status,
   input  logic [tcw_pkg::CHAR_W-1:0]        req_char_code,
   input  logic [tcw_pkg::READ_ROW_W-1:0]    req_read_row,
   input  logic [tcw_pkg::READ_COL_W-1:0]    req_read_col,
   input  logic                              csr_we,
   input  logic [tcw_pkg::PAL_W-1:0]         csr_palette_select,
   output logic                              rsp_strobe,
   output logic [tcw_pkg::CELL_W-1:0]        rsp_cell_value,
   output logic [tcw_pkg::CUR_COL_W-1:0]     rsp_cursor_col,
   output logic [tcw_pkg::CUR_ROW_W-1:0]     rsp_cursor_row
);
   import tcw_pkg::*;

   localparam int CELLS     = COLUMNS * ROWS;
   localparam int AW        = $clog2(CELLS);
   localparam int CW        = $clog2(COLUMNS + 1);
   localparam int RW        = $clog2(ROWS);
   localparam int COPY_LAST = CELLS - COLUMNS - 1;

   logic [CELL_W-1:0] mem [CELLS];
   logic [CELL_W-1:0] rdata_ff;

   logic [CW-1:0]        col_ff, col_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [PAL_W-1:0]     palette_ff, palette_in;
   logic [CHAR_W-1:0]    code_ff, code_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic [AW-1:0]        sweep_ff, sweep_in;
   logic                 cpy_pend_ff, cpy_pend_in;
   logic [AW-1:0]        cpy_addr_ff, cpy_addr_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [CELL_W-1:0]    rsp_cell_ff, rsp_cell_in;
   logic [CUR_COL_W-1:0] rsp_col_ff, rsp_col_in;
   logic [CUR_ROW_W-1:0] rsp_row_ff, rsp_row_in;

   logic              at_bottom;
   logic              rd_in_range;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     cur_addr;
   logic [AW-1:0]     copy_raddr;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;

   assign at_bottom   = (row_ff == RW'(ROWS - 1));
   assign rd_in_range = (int'(req_read_row) < ROWS) && (int'(req_read_col) < COLUMNS);
   assign rd_addr     = rd_in_range ?
                        AW'(AW'(req_read_row) * AW'(COLUMNS) + AW'(req_read_col)) : '0;
   assign cur_addr    = AW'(AW'(row_ff) * AW'(COLUMNS) + AW'(col_ff));
   assign copy_raddr  = sweep_ff + AW'(COLUMNS);

   assign status.printable  = (req_char_code >= FIRST_PRINTABLE) &&
                              (req_char_code <= LAST_PRINTABLE);
   assign status.wrap       = (col_ff == CW'(COLUMNS));
   assign status.at_bottom  = at_bottom;
   assign status.copy_last  = (sweep_ff == AW'(COPY_LAST));
   assign status.sweep_last = (sweep_ff == AW'(CELLS - 1));
   assign status.copy_pend  = cpy_pend_ff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      unique case (cmd.cur_op)
         CUR_HOLD: begin
         end
         CUR_HOME: begin
            col_in = '0;
            row_in = '0;
         end
         CUR_NEWLINE: begin
            col_in = '0;
            if (!at_bottom) begin
               row_in = row_ff + RW'(1);
            end
         end
         CUR_ADVANCE: begin
            col_in = col_ff + CW'(1);
         end
      endcase
   end

   always_comb begin
      palette_in    = csr_we ? csr_palette_select : palette_ff;
      code_in       = cmd.req_load ? req_char_code : code_ff;
      rd_ok_in      = cmd.req_load ? (cmd.read_req && rd_in_range) : rd_ok_ff;
      cpy_pend_in   = cmd.copy;
      cpy_addr_in   = sweep_ff;
      rsp_strobe_in = cmd.respond;
      rsp_cell_in   = rd_ok_ff ? rdata_ff : '0;
      rsp_col_in    = CUR_COL_W'(col_ff);
      rsp_row_in    = CUR_ROW_W'(row_ff);
      if (cmd.sweep_clr) begin
         sweep_in = '0;
      end else if (cmd.sweep_inc) begin
         sweep_in = sweep_ff + AW'(1);
      end else begin
         sweep_in = sweep_ff;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = sweep_ff;
      mem_wdata = '0;
      priority if (cpy_pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = cpy_addr_ff;
         mem_wdata = rdata_ff;
      end else if (cmd.write_zero) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_ff;
      end else if (cmd.write_char) begin
         mem_we    = 1'b1;
         mem_waddr = cur_addr;
         mem_wdata = {palette_ff, TILE_CODE_W'(code_ff - FIRST_PRINTABLE)};
      end else begin
         mem_we = 1'b0;
      end
      mem_re    = cmd.read_req || cmd.copy;
      mem_raddr = cmd.copy ? copy_raddr : rd_addr;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         palette_ff    <= PALETTE_RESET;
         sweep_ff      <= '0;
         cpy_pend_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         palette_ff    <= palette_in;
         sweep_ff      <= sweep_in;
         cpy_pend_ff   <= cpy_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      rd_ok_ff    <= rd_ok_in;
      cpy_addr_ff <= cpy_addr_in;
      if (cmd.respond) begin
         rsp_cell_ff <= rsp_cell_in;
         rsp_col_ff  <= rsp_col_in;
         rsp_row_ff  <= rsp_row_in;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;

endmodule

FILE: rtl/text_console_tile_writer.sv
// Top level of the text console tile writer.
//
// A request transfers at a rising edge where start is high and busy is low:
// req_func selects print, newline, clear or read, with req_char_code or
// req_read_row/req_read_col as operands. Each request gives exactly one
// result: rsp_strobe is high for one cycle with rsp_cell_value and the
// cursor after the request. The receiver cannot stall results.
// A read, an ignored character or a newline that does not scroll goes
// straight to the response; a printed character first writes its cell.
// A scroll copies the map one cell per cycle through the map memory and
// then fills the last row; a character that wraps and scrolls is written
// after the fill. A clear zeroes one cell per cycle. busy stays high for
// the whole request, so requests do not overlap.
// After reset the block zeroes the map, with busy high.
// The palette register transfers on csr_valid, which is always ready.
module text_console_tile_writer #(
   parameter int COLUMNS = 32,
   parameter int ROWS    = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tcw_pkg::FUNC_W-1:0]        req_func,
   input  logic [tcw_pkg::CHAR_W-1:0]        req_char_code,
   input  logic [tcw_pkg::READ_ROW_W-1:0]    req_read_row,
   input  logic [tcw_pkg::READ_COL_W-1:0]    req_read_col,
   output logic                              rsp_strobe,
   output logic [tcw_pkg::CELL_W-1:0]        rsp_cell_value,
   output logic [tcw_pkg::CUR_COL_W-1:0]     rsp_cursor_col,
   output logic [tcw_pkg::CUR_ROW_W-1:0]     rsp_cursor_row,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tcw_pkg::PAL_W-1:0]         csr_palette_select
);
   import tcw_pkg::*;

`include "text_console_tile_writer_assert.svh"

   tcw_cmd_type    cmd;
   tcw_status_type status;

   assign csr_ready = 1'b1;

   tcw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_char_code      (req_char_code),
      .req_read_row       (req_read_row),
      .req_read_col       (req_read_col),
      .csr_we             (csr_valid && csr_ready),
      .csr_palette_select (csr_palette_select),
      .rsp_strobe         (rsp_strobe),
      .rsp_cell_value     (rsp_cell_value),
      .rsp_cursor_col     (rsp_cursor_col),
      .rsp_cursor_row     (rsp_cursor_row)
   );

   `TCW_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `TCW_ASSERT_SAME(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `TCW_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `TCW_ASSERT_SAME(a_col_range, clock, reset, rsp_strobe, rsp_cursor_col <= COLUMNS)

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the text console tile writer, with a cycle-free console model.
`timescale 1ns / 1ps

module testbench;
   import tcw_pkg::*;

   localparam int COLUMNS = 32;
   localparam int ROWS = 24;
   localparam int CELLS = COLUMNS * ROWS;
   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int DIRECTED_STEPS = 22;

   typedef struct packed {
      logic [CELL_W-1:0]    tile;
      logic [CUR_COL_W-1:0] col;
      logic [CUR_ROW_W-1:0] row;
   } console_reply_type;

   typedef struct packed {
      tcw_func_type          func;
      logic [CHAR_W-1:0]     code;
      logic [READ_ROW_W-1:0] row;
      logic [READ_COL_W-1:0] col;
      logic                  known;
      console_reply_type     reply;
   } console_step_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [FUNC_W-1:0]     req_func;
   logic [CHAR_W-1:0]     req_char_code;
   logic [READ_ROW_W-1:0] req_read_row;
   logic [READ_COL_W-1:0] req_read_col;
   logic                  rsp_strobe;
   logic [CELL_W-1:0]     rsp_cell_value;
   logic [CUR_COL_W-1:0]  rsp_cursor_col;
   logic [CUR_ROW_W-1:0]  rsp_cursor_row;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [PAL_W-1:0]      csr_palette_select;

   logic [CELL_W-1:0] shadow_map [0:CELLS-1];
   int                shadow_col;
   int                shadow_row;
   logic [PAL_W-1:0]  shadow_palette;

   console_reply_type replies_due [$];
   console_reply_type head_reply;
   int                mismatches = 0;
   int                items_sent = 0;
   bit                no_idle = 0;

   console_step_type directed_steps [DIRECTED_STEPS] = '{
      '{FUNC_READ,    8'hFF, 5'd0,  5'd0,  1'b1, '{16'h0000, 6'd0, 5'd0}},
      '{FUNC_READ,    8'h00, 5'd23, 5'd31, 1'b1, '{16'h0000, 6'd0, 5'd0}},
      '{FUNC_READ,    8'h00, 5'd24, 5'd0,  1'b1, '{16'h0000, 6'd0, 5'd0}},
      '{FUNC_READ,    8'h00, 5'd31, 5'd31, 1'b1, '{16'h0000, 6'd0, 5'd0}},
      '{FUNC_PRINT,   8'd32, 5'd31, 5'd31, 1'b1, '{16'h0000, 6'd1, 5'd0}},
      '{FUNC_PRINT,   8'd127, 5'd0, 5'd0,  1'b1, '{16'h0000, 6'd2, 5'd0}},
      '{FUNC_PRINT,   8'd31, 5'd0,  5'd0,  1'b1, '{16'h0000, 6'd2, 5'd0}},
      '{FUNC_PRINT,   8'd128, 5'd0, 5'd0,  1'b1, '{16'h0000, 6'd2, 5'd0}},
      '{FUNC_PRINT,   8'd255, 5'd0, 5'd0,  1'b1, '{16'h0000, 6'd2, 5'd0}},
      '{FUNC_PRINT,   8'd0,  5'd0,  5'd0,  1'b1, '{16'h0000, 6'd2, 5'd0}},
      '{FUNC_PRINT,   8'd65, 5'd7,  5'd9,  1'b0, '{16'h0000, 6'd0, 5'd0}},
      '{FUNC_READ,    8'hAA, 5'd0,  5'd0,  1'b1, '{16'hF000, 6'd3, 5'd0}},
      '{FUNC_READ,    8'h55, 5'd0,  5'd1,  1'b1, '{16'hF05F, 6'd3, 5'd0}},
      '{FUNC_READ,    8'h00, 5'd0,  5'd2,  1'b0, '{16'h0000, 6'd0, 5'd0}},
      '{FUNC_NEWLINE, 8'h41, 5'd5,  5'd7,  1'b1, '{16'h0000, 6'd0, 5'd1}},
      '{FUNC_PRINT,   8'd90, 5'd0,  5'd0,  1'b0, '{16'h0000, 6'd0, 5'd0}},
      '{FUNC_READ,    8'h00, 5'd1,  5'd0,  1'b0, '{16'h0000, 6'd0, 5'd0}},
      '{FUNC_CLEAR,   8'hFF, 5'd31, 5'd31, 1'b1, '{16'h0000, 6'd0, 5'd0}},
      '{FUNC_READ,    8'h00, 5'd0,  5'd0,  1'b1, '{16'h0000, 6'd0, 5'd0}},
      '{FUNC_READ,    8'h00, 5'd1,  5'd0,  1'b1, '{16'h0000, 6'd0, 5'd0}},
      '{FUNC_NEWLINE, 8'h00, 5'd0,  5'd0,  1'b1, '{16'h0000, 6'd0, 5'd1}},
      '{FUNC_CLEAR,   8'h00, 5'd0,  5'd0,  1'b1, '{16'h0000, 6'd0, 5'd0}}
   };

   text_console_tile_writer #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_char_code(req_char_code),
      .req_read_row(req_read_row),
      .req_read_col(req_read_col),
      .rsp_strobe(rsp_strobe),
      .rsp_cell_value(rsp_cell_value),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_palette_select(csr_palette_select)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #80_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic void console_line_feed();
      int i;
      shadow_col = 0;
      if (shadow_row + 1 < ROWS) begin
         shadow_row++;
      end else begin
         shadow_row = ROWS - 1;
         for (i = 0; i < CELLS - COLUMNS; i++) shadow_map[i] = shadow_map[i + COLUMNS];
         for (i = CELLS - COLUMNS; i < CELLS; i++) shadow_map[i] = '0;
      end
   endfunction

   function automatic void console_clear();
      int i;
      for (i = 0; i < CELLS; i++) shadow_map[i] = '0;
      shadow_col = 0;
      shadow_row = 0;
   endfunction

   function automatic console_reply_type console_apply(tcw_func_type func,
                                                       logic [CHAR_W-1:0] code,
                                                       logic [READ_ROW_W-1:0] row,
                                                       logic [READ_COL_W-1:0] col);
      console_reply_type reply;
      reply.tile = '0;
      unique case (func)
         FUNC_PRINT: begin
            if (code >= FIRST_PRINTABLE && code <= LAST_PRINTABLE) begin
               if (shadow_col >= COLUMNS) console_line_feed();
               shadow_map[shadow_row * COLUMNS + shadow_col] =
                  {shadow_palette, TILE_CODE_W'(code - FIRST_PRINTABLE)};
               shadow_col++;
            end
         end
         FUNC_NEWLINE: console_line_feed();
         FUNC_CLEAR: console_clear();
         default: begin
            if (row < ROWS && col < COLUMNS) reply.tile = shadow_map[row * COLUMNS + col];
         end
      endcase
      reply.col = CUR_COL_W'(shadow_col);
      reply.row = CUR_ROW_W'(shadow_row);
      return reply;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (mismatches < 100) $display("mismatch on %s: got %0h, want %0h", what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (replies_due.size() == 0) begin
            report_mismatch("unexpected result", rsp_cell_value, 0);
         end else begin
            head_reply = replies_due.pop_front();
            if (rsp_cell_value !== head_reply.tile)
               report_mismatch("cell_value", rsp_cell_value, head_reply.tile);
            if (rsp_cursor_col !== head_reply.col)
               report_mismatch("cursor_col", rsp_cursor_col, head_reply.col);
            if (rsp_cursor_row !== head_reply.row)
               report_mismatch("cursor_row", rsp_cursor_row, head_reply.row);
         end
      end
   end

   task automatic send_item(tcw_func_type func, logic [CHAR_W-1:0] code,
                            logic [READ_ROW_W-1:0] row, logic [READ_COL_W-1:0] col,
                            bit known = 1'b0, console_reply_type given = '0);
      console_reply_type reply;
      @(negedge clock);
      start = 1'b1;
      req_func = func;
      req_char_code = code;
      req_read_row = row;
      req_read_col = col;
      do @(posedge clock); while (busy);
      reply = console_apply(func, code, row, col);
      if (known) reply = given;
      replies_due.push_back(reply);
      items_sent++;
   endtask

   task automatic sender_gap();
      int pick;
      int cycles;
      pick = $urandom_range(0, 99);
      if (no_idle || pick < 55) cycles = 0;
      else if (pick < 85) cycles = $urandom_range(1, 3);
      else if (pick < 97) cycles = $urandom_range(4, 20);
      else cycles = $urandom_range(50, 200);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
         req_func = FUNC_W'($urandom);
         req_char_code = CHAR_W'($urandom);
         req_read_row = READ_ROW_W'($urandom);
         req_read_col = READ_COL_W'($urandom);
      end
   endtask

   task automatic drain_replies();
      @(negedge clock);
      start = 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_palette(logic [PAL_W-1:0] value);
      drain_replies();
      repeat (3) @(negedge clock);
      csr_valid = 1'b1;
      csr_palette_select = value;
      do @(posedge clock); while (!csr_ready);
      shadow_palette = value;
      @(negedge clock);
      csr_valid = 1'b0;
      csr_palette_select = PAL_W'($urandom);
   endtask

   function automatic logic [CHAR_W-1:0] unprintable_code();
      if ($urandom_range(0, 1) == 0) return CHAR_W'($urandom_range(0, 31));
      return CHAR_W'($urandom_range(128, 255));
   endfunction

   function automatic logic [READ_ROW_W-1:0] probe_row();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return READ_ROW_W'(shadow_row);
      if (pick < 9) return READ_ROW_W'($urandom_range(0, ROWS - 1));
      return READ_ROW_W'($urandom_range(ROWS, 31));
   endfunction

   task automatic send_text_line();
      int length;
      int pick;
      length = $urandom_range(0, 45);
      repeat (length) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            send_item(FUNC_PRINT, unprintable_code(), READ_ROW_W'($urandom),
                      READ_COL_W'($urandom));
         else if (pick < 20)
            send_item(FUNC_READ, CHAR_W'($urandom), probe_row(), READ_COL_W'($urandom));
         else
            send_item(FUNC_PRINT, CHAR_W'($urandom_range(32, 127)), READ_ROW_W'($urandom),
                      READ_COL_W'($urandom));
         sender_gap();
      end
      if ($urandom_range(0, 4) != 0) begin
         send_item(FUNC_NEWLINE, CHAR_W'($urandom), READ_ROW_W'($urandom),
                   READ_COL_W'($urandom));
         sender_gap();
      end
   endtask

   task automatic send_noise();
      tcw_func_type func;
      func = tcw_func_type'(FUNC_W'($urandom_range(0, 3)));
      if (func == FUNC_CLEAR && $urandom_range(0, 3) != 0) func = FUNC_READ;
      send_item(func, CHAR_W'($urandom), READ_ROW_W'($urandom), READ_COL_W'($urandom));
      sender_gap();
   endtask

   task automatic run_sequence();
      int pick;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3) drain_replies();
      if (pick < 62) begin
         send_text_line();
      end else if (pick < 66) begin
         send_item(FUNC_CLEAR, CHAR_W'($urandom), READ_ROW_W'($urandom),
                   READ_COL_W'($urandom));
         sender_gap();
      end else begin
         send_noise();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_func = '0;
      req_char_code = '0;
      req_read_row = '0;
      req_read_col = '0;
      csr_valid = 1'b0;
      csr_palette_select = '0;
      console_clear();
      shadow_palette = PALETTE_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_steps[i]) begin
         send_item(directed_steps[i].func, directed_steps[i].code, directed_steps[i].row,
                   directed_steps[i].col, directed_steps[i].known, directed_steps[i].reply);
         sender_gap();
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: write_palette(4'h0);
            1: write_palette(4'hF);
            2: write_palette(4'hA);
            4: write_palette(4'h5);
            default: write_palette(PAL_W'($urandom));
         endcase
         no_idle = (phase == 2);
         while (items_sent < DIRECTED_STEPS + (phase + 1) * ITEMS_PER_PHASE) run_sequence();
      end

      drain_replies();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
